// ----- sv/trt_pkg.sv -----
// ----------------------------------------------------------------------------
// trt_pkg: shared types and codes for the tag registry table
// Command and status codes, the request token that walks the cell chain
// and the write commit broadcast back to the cells.
// ----------------------------------------------------------------------------
package trt_pkg;

  localparam int unsigned TagW = 40;
  localparam int unsigned IdW  = 8;
  // index width for the largest supported table (64 entries)
  localparam int unsigned IdxW = 6;

  // command codes; the unused code behaves as a lookup
  localparam logic [1:0] CmdLookup   = 2'd0;
  localparam logic [1:0] CmdRegister = 2'd1;
  localparam logic [1:0] CmdClear    = 2'd2;

  // status codes
  localparam logic [2:0] StFound   = 3'd0;
  localparam logic [2:0] StAbsent  = 3'd1;
  localparam logic [2:0] StStored  = 3'd2;
  localparam logic [2:0] StFull    = 3'd3;
  localparam logic [2:0] StCleared = 3'd4;

  // erased entry contents
  localparam logic [TagW-1:0] TagErased = '1;
  localparam logic [IdW-1:0]  IdErased  = '1;

  // request token handed from cell to cell
  typedef struct packed {
    logic            valid;
    logic [1:0]      cmd;
    logic [TagW-1:0] tag;
    logic            found;
    logic [IdW-1:0]  id;
    logic            free_seen;
    logic [IdxW-1:0] free_idx;
  } token_t;

  // store request broadcast from the end of the chain
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] idx;
    logic [TagW-1:0] tag;
  } commit_t;

endpackage

// ----- sv/tag_registry_table_top.sv -----
// ----------------------------------------------------------------------------
// tag_registry_table_top: card tag table with lookup and first-free insert
// Chain of entry cells walked by one request at a time.
// ----------------------------------------------------------------------------
// One request is in the table at a time. An accepted request is registered,
// then walks the chain of ENTRIES cells one cell per cycle; the next request
// is taken once the current one has left the chain and the overflow slot is
// empty. Lookup returns the id of the lowest matching entry. Register stores
// an absent tag in the lowest entry whose two leading tag bytes are 0xFF,
// with id index + 1, and the store lands as the request leaves the chain.
// Clear erases each entry to all ones as the request passes it. Reset
// erases the table at once, with no clearing pass. A finished result waits
// in an output register, backed by one extra slot, so a new request can
// enter while the previous result is still unclaimed.
// ----------------------------------------------------------------------------
module tag_registry_table_top #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [39:0] tag_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  card_id_o
);

  trt_pkg::token_t  token_w [ENTRIES+1];
  trt_pkg::commit_t commit;
  trt_pkg::token_t  tail;

  logic             in_accept;
  logic             busy_q, busy_d;
  logic             req_valid_q;
  logic [1:0]       req_cmd_q;
  logic [39:0]      req_tag_q;

  logic [2:0]       res_status;
  logic [7:0]       res_id;

  logic             out_valid_q, out_valid_d;
  logic [2:0]       out_status_q, out_status_d;
  logic [7:0]       out_id_q, out_id_d;
  logic             hold_valid_q, hold_valid_d;
  logic [2:0]       hold_status_q, hold_status_d;
  logic [7:0]       hold_id_q, hold_id_d;
  logic             out_take;

  // request intake
  assign in_stall_o = busy_q || hold_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      busy_q      <= 1'b0;
    end else begin
      req_valid_q <= in_accept;
      busy_q      <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_cmd_q <= command_i;
      req_tag_q <= tag_i;
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (in_accept) begin
      busy_d = 1'b1;
    end else if (tail.valid) begin
      busy_d = 1'b0;
    end
  end

  // head token
  always_comb begin
    token_w[0]           = '0;
    token_w[0].valid     = req_valid_q;
    token_w[0].cmd       = req_cmd_q;
    token_w[0].tag       = req_tag_q;
  end

  // cell chain
  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    trt_cell #(
      .CellIdx(trt_pkg::IdxW'(k))
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .token_i (token_w[k]),
      .commit_i(commit),
      .token_o (token_w[k+1])
    );
  end

  assign tail = token_w[ENTRIES];

  // result and store decision at the end of the chain
  always_comb begin
    commit.we  = 1'b0;
    commit.idx = tail.free_idx;
    commit.tag = tail.tag;
    res_id     = '0;
    if (tail.cmd == trt_pkg::CmdClear) begin
      res_status = trt_pkg::StCleared;
    end else if (tail.found) begin
      res_status = trt_pkg::StFound;
      res_id     = tail.id;
    end else if (tail.cmd == trt_pkg::CmdRegister) begin
      if (tail.free_seen) begin
        res_status = trt_pkg::StStored;
        res_id     = 8'(tail.free_idx) + 8'd1;
        commit.we  = tail.valid;
      end else begin
        res_status = trt_pkg::StFull;
      end
    end else begin
      res_status = trt_pkg::StAbsent;
    end
  end

  // output register with one overflow slot
  assign out_take = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d   = out_valid_q;
    out_status_d  = out_status_q;
    out_id_d      = out_id_q;
    hold_valid_d  = hold_valid_q;
    hold_status_d = hold_status_q;
    hold_id_d     = hold_id_q;
    if (out_take) begin
      out_valid_d = 1'b0;
    end
    if (hold_valid_q && (out_take || !out_valid_q)) begin
      out_valid_d  = 1'b1;
      out_status_d = hold_status_q;
      out_id_d     = hold_id_q;
      hold_valid_d = 1'b0;
    end
    if (tail.valid) begin
      if (out_valid_q && !out_take) begin
        hold_valid_d  = 1'b1;
        hold_status_d = res_status;
        hold_id_d     = res_id;
      end else begin
        out_valid_d  = 1'b1;
        out_status_d = res_status;
        out_id_d     = res_id;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q  <= out_status_d;
    out_id_q      <= out_id_d;
    hold_status_q <= hold_status_d;
    hold_id_q     <= hold_id_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign card_id_o   = out_id_q;

  // checks
  a_hold_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_valid_q |-> out_valid_q)
    else $error("overflow slot filled while output register empty");

  a_tail_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> busy_q)
    else $error("request left the chain while table idle");

  a_tail_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |=> !busy_q)
    else $error("table still busy after request finished");

  a_no_tail_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> !hold_valid_q)
    else $error("finished request with overflow slot already full");

endmodule

// ----- sv/trt_cell.sv -----
// ----------------------------------------------------------------------------
// trt_cell: one table entry of the tag registry chain
// Holds one tag and id, compares the tag against the passing request token,
// notes the first free entry, erases itself on clear and takes a store
// request addressed to its own index.
// ----------------------------------------------------------------------------
module trt_cell #(
  parameter logic [trt_pkg::IdxW-1:0] CellIdx = '0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  trt_pkg::token_t   token_i,
  input  trt_pkg::commit_t  commit_i,
  output trt_pkg::token_t   token_o
);

  logic [trt_pkg::TagW-1:0] tag_q, tag_d;
  logic [trt_pkg::IdW-1:0]  id_q, id_d;
  logic                     valid_q;
  trt_pkg::token_t          token_d, token_q;
  logic                     entry_free;
  logic                     entry_hit;

  assign entry_free = (tag_q[trt_pkg::TagW-1 -: 16] == 16'hFFFF);
  assign entry_hit  = (tag_q == token_i.tag);

  // compare and first-free search for the passing request
  always_comb begin
    token_d = token_i;
    if (!token_i.found && entry_hit) begin
      token_d.found = 1'b1;
      token_d.id    = id_q;
    end
    if (!token_i.free_seen && entry_free) begin
      token_d.free_seen = 1'b1;
      token_d.free_idx  = CellIdx;
    end
  end

  // entry update: clear request or store commit
  always_comb begin
    tag_d = tag_q;
    id_d  = id_q;
    if (token_i.valid && (token_i.cmd == trt_pkg::CmdClear)) begin
      tag_d = trt_pkg::TagErased;
      id_d  = trt_pkg::IdErased;
    end else if (commit_i.we && (commit_i.idx == CellIdx)) begin
      tag_d = commit_i.tag;
      id_d  = trt_pkg::IdW'(CellIdx) + trt_pkg::IdW'(1);
    end
  end

  // entry storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= trt_pkg::TagErased;
      id_q  <= trt_pkg::IdErased;
    end else begin
      tag_q <= tag_d;
      id_q  <= id_d;
    end
  end

  // token stage toward the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= token_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    token_q <= token_d;
  end

  always_comb begin
    token_o       = token_q;
    token_o.valid = valid_q;
  end

endmodule
